FILE: design/mlpbp_pkg.sv
// Shared constants, codes and sigmoid table builder for the MLP training block.
package mlpbp_pkg;

  localparam int MODE_W   = 2;
  localparam int X_W      = 16;
  localparam int T_W      = 13;
  localparam int WIDX_W   = 4;
  localparam int W_W      = 20;
  localparam int LR_W     = 13;
  localparam int Y_W      = 13;

  localparam logic [MODE_W-1:0] MODE_TRAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INFER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  localparam logic [LR_W-1:0] LR_RESET = 13'd3277;
  localparam logic [T_W-1:0]  ONE_Q12  = 13'd4096;

  localparam logic signed [23:0] W_MAX = 24'sd524287;
  localparam logic signed [23:0] W_MIN = -24'sd524288;

  // Shared multiplier operand and product widths, and the accumulator width
  localparam int MA_W  = 33;
  localparam int MB_W  = 18;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 48;

  localparam longint unsigned BASE_Q20   = 64'd2850030;
  localparam longint unsigned LNBASE_Q20 = 64'd1048467;
  localparam longint unsigned ONE_Q20    = 64'd1048576;

  // Unsigned quotient by shift and subtract, used only while building the table
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid of a non-negative Q12 argument, Q0.12 result
  function automatic longint unsigned sig_pos(longint unsigned a);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned t;
    longint unsigned ip;
    p    = ONE_Q20;
    sum  = ONE_Q20;
    term = ONE_Q20;
    ip   = a >> 12;
    for (longint unsigned k = 0; k < ip; k++) begin
      p = (p * BASE_Q20 + (ONE_Q20 >> 1)) >> 20;
    end
    t = ((a & 64'd4095) * LNBASE_Q20) >> 12;
    for (longint unsigned k = 1; k <= 12; k++) begin
      term = udiv(term * t, k * ONE_Q20);
      sum  = sum + term;
    end
    p = (p * sum + (ONE_Q20 >> 1)) >> 20;
    return udiv(64'd4096 * p + ((p + ONE_Q20) >> 1), p + ONE_Q20);
  endfunction

  // Table entry i of n over the argument range [-8, 8]
  function automatic logic [Y_W-1:0] sig_entry(longint unsigned i, longint unsigned n);
    longint a;
    longint unsigned v;
    a = longint'(udiv(i * 64'd65536, n)) - 64'sd32768;
    if (a >= 0) v = sig_pos(longint'(a));
    else        v = 64'd4096 - sig_pos(longint'(-a));
    return v[Y_W-1:0];
  endfunction

endpackage

FILE: design/mlp_backprop_train_step.sv
// Every product goes through one shared 33x18 multiplier; each multiply-accumulate
// passes through read, multiply and accumulate states, and each sigmoid lookup through
// scale, low-entry, high-entry, interpolate and finish states.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: weights read as zero (valid bits cleared), learning rate 3277, no result pending.
module mlp_backprop_train_step #(
  parameter int HIDDEN_UNITS    = 3,
  parameter int INPUT_COUNT     = 2,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mlpbp_pkg::LR_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mlpbp_pkg::MODE_W-1:0]      mode,
  input  logic signed [mlpbp_pkg::X_W-1:0]  x_first,
  input  logic signed [mlpbp_pkg::X_W-1:0]  x_second,
  input  logic [mlpbp_pkg::T_W-1:0]         target,
  input  logic [mlpbp_pkg::WIDX_W-1:0]      weight_index,
  input  logic signed [mlpbp_pkg::W_W-1:0]  weight_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mlpbp_pkg::Y_W-1:0]         net_output,
  output logic signed [mlpbp_pkg::W_W-1:0]  weight_read,
  output logic                              saturated
);
  import mlpbp_pkg::*;

  localparam int ROW_LEN   = INPUT_COUNT + 1;
  localparam int HID_COUNT = HIDDEN_UNITS * ROW_LEN;
  localparam int TOTAL     = HID_COUNT + HIDDEN_UNITS + 1;
  localparam int WI_W      = $clog2(TOTAL);
  localparam int CNT_W     = $clog2(ROW_LEN + HIDDEN_UNITS + 1);
  localparam int IDX_W     = $clog2(SIGMOID_ENTRIES + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_READ   = 5'd2;
  localparam logic [4:0] S_READ2  = 5'd3;
  localparam logic [4:0] S_F_RD   = 5'd4;
  localparam logic [4:0] S_F_MUL  = 5'd5;
  localparam logic [4:0] S_F_ACC  = 5'd6;
  localparam logic [4:0] S_SG_U   = 5'd7;
  localparam logic [4:0] S_SG_LO  = 5'd8;
  localparam logic [4:0] S_SG_HI  = 5'd9;
  localparam logic [4:0] S_SG_MUL = 5'd10;
  localparam logic [4:0] S_SG_FIN = 5'd11;
  localparam logic [4:0] S_D1     = 5'd12;
  localparam logic [4:0] S_D2     = 5'd13;
  localparam logic [4:0] S_D3     = 5'd14;
  localparam logic [4:0] S_H_RD   = 5'd15;
  localparam logic [4:0] S_H_MUL1 = 5'd16;
  localparam logic [4:0] S_H_MUL2 = 5'd17;
  localparam logic [4:0] S_H_MUL3 = 5'd18;
  localparam logic [4:0] S_H_FIN  = 5'd19;
  localparam logic [4:0] S_U_A    = 5'd20;
  localparam logic [4:0] S_U_B    = 5'd21;
  localparam logic [4:0] S_U_WR   = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  typedef logic [Y_W-1:0] rom_t [0:SIGMOID_ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= SIGMOID_ENTRIES; i++) begin
      r[i] = sig_entry(longint'(i), longint'(SIGMOID_ENTRIES));
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  logic [4:0]              state;
  logic [LR_W-1:0]         lr;
  logic [MODE_W-1:0]       mode_q;
  logic signed [X_W-1:0]   x_q [INPUT_COUNT];
  logic [T_W-1:0]          tgt_q;
  logic                    idx_ok;
  logic signed [W_W-1:0]   wval_q;
  logic [WI_W-1:0]         widx;
  logic [CNT_W-1:0]        c;
  logic [CNT_W-1:0]        h;
  logic                    layer_out;
  logic signed [ACC_W-1:0] acc;
  logic [Y_W-1:0]          z_q [HIDDEN_UNITS];
  logic signed [18:0]      dh_q [HIDDEN_UNITS];
  logic [Y_W-1:0]          y_q;
  logic signed [13:0]      delta_q;
  logic                    clip;
  logic signed [W_W-1:0]   res_w;
  logic [IDX_W-1:0]        sidx;
  logic [15:0]             sfrac;
  logic [Y_W-1:0]          rom_q;
  logic [Y_W-1:0]          lo_q;

  // Shared multiplier
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;

  // Weight memory
  logic signed [W_W-1:0]   wmem [TOTAL];
  logic [TOTAL-1:0]        wvld;
  logic signed [W_W-1:0]   wrd;
  logic                    w_en;
  logic signed [W_W-1:0]   w_data;

  logic [X_W-1:0]          x_sel;
  logic [Y_W-1:0]          z_sel;
  logic [Y_W-1:0]          zh_sel;
  logic signed [18:0]      dh_sel;
  logic signed [MB_W-1:0]  term_b;
  logic                    last_term;
  logic                    last_h;
  logic signed [ACC_W-13:0] a_s;
  logic signed [ACC_W-12:0] a_off;
  logic [16:0]             sg_arg;
  logic [IDX_W-1:0]        idx_c;
  logic [IDX_W-1:0]        rom_addr;
  logic signed [13:0]      sg_diff;
  logic signed [14:0]      sg_sum;
  logic signed [22:0]      upd;
  logic signed [23:0]      wsum;
  logic                    wclip;
  logic [31:0]             idx32;

  assign in_ready  = (state == S_IDLE);
  assign last_h    = (h == CNT_W'(HIDDEN_UNITS - 1));
  assign last_term = layer_out ? (c == CNT_W'(HIDDEN_UNITS)) : (c == CNT_W'(ROW_LEN - 1));
  assign idx32     = 32'(weight_index);

  always_comb begin
    x_sel  = '0;
    z_sel  = '0;
    zh_sel = '0;
    dh_sel = '0;
    for (int i = 0; i < INPUT_COUNT; i++) begin
      if (c == CNT_W'(i + 1)) x_sel = x_q[i];
    end
    for (int i = 0; i < HIDDEN_UNITS; i++) begin
      if (c == CNT_W'(i + 1)) z_sel = z_q[i];
      if (h == CNT_W'(i)) begin
        zh_sel = z_q[i];
        dh_sel = dh_q[i];
      end
    end
    if (c == '0)       term_b = MB_W'(4096);
    else if (layer_out) term_b = $signed({5'b0, z_sel});
    else               term_b = $signed({{(MB_W-X_W){x_sel[X_W-1]}}, x_sel});
  end

  // Sigmoid argument: floor to Q12, clamp to [-8, 8], offset to [0, 16]
  always_comb begin
    a_s   = acc[ACC_W-1:12];
    a_off = a_s + (ACC_W-11)'(32768);
    if (a_s < -(ACC_W-12)'(32768))     sg_arg = 17'd0;
    else if (a_s > (ACC_W-12)'(32768)) sg_arg = 17'd65536;
    else                               sg_arg = a_off[16:0];
    idx_c    = mul_p[16 +: IDX_W];
    rom_addr = (state == S_SG_LO) ? idx_c :
               ((sidx == IDX_W'(SIGMOID_ENTRIES)) ? sidx : sidx + 1'b1);
    sg_diff  = $signed({1'b0, rom_q}) - $signed({1'b0, lo_q});
    sg_sum   = $signed({2'b0, lo_q}) + $signed(mul_p[29:16]);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_F_MUL: begin
        mul_a = MA_W'(wrd);
        mul_b = term_b;
      end
      S_SG_U: begin
        mul_a = $signed({16'b0, sg_arg});
        mul_b = MB_W'(SIGMOID_ENTRIES);
      end
      S_SG_MUL: begin
        mul_a = MA_W'(sg_diff);
        mul_b = $signed({2'b0, sfrac});
      end
      S_D1: begin
        mul_a = MA_W'($signed({1'b0, tgt_q}) - $signed({1'b0, y_q}));
        mul_b = $signed({5'b0, y_q});
      end
      S_D2: begin
        mul_a = mul_p[MA_W-1:0];
        mul_b = $signed({5'b0, ONE_Q12 - y_q});
      end
      S_H_MUL1: begin
        mul_a = MA_W'(wrd);
        mul_b = MB_W'(delta_q);
      end
      S_H_MUL2: begin
        mul_a = MA_W'($signed(mul_p[30:12]));
        mul_b = $signed({5'b0, zh_sel});
      end
      S_H_MUL3: begin
        mul_a = mul_p[MA_W-1:0];
        mul_b = $signed({5'b0, ONE_Q12 - zh_sel});
      end
      S_U_A: begin
        mul_a = layer_out ? MA_W'(delta_q) : MA_W'(dh_sel);
        mul_b = $signed({5'b0, lr});
      end
      S_U_B: begin
        mul_a = mul_p[MA_W-1:0];
        mul_b = term_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Weight update with saturation to Q8.12, or the loaded value in load mode
  always_comb begin
    upd   = mul_p[46:24];
    wsum  = 24'(wrd) + 24'(upd);
    wclip = 1'b0;
    if (wsum > W_MAX) begin
      wclip = 1'b1;
      w_data = W_MAX[W_W-1:0];
    end else if (wsum < W_MIN) begin
      wclip = 1'b1;
      w_data = W_MIN[W_W-1:0];
    end else begin
      w_data = wsum[W_W-1:0];
    end
    if (state == S_LOAD) w_data = wval_q;
    w_en = (state == S_U_WR) || (state == S_LOAD && idx_ok);
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    rom_q <= SIG_ROM[rom_addr];
    if (w_en) wmem[widx] <= w_data;
    wrd <= wvld[widx] ? wmem[widx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvld <= '0;
    end else if (w_en) begin
      wvld[widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lr <= LR_RESET;
    end else if (cfg_write) begin
      lr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            for (int i = 0; i < INPUT_COUNT; i++) begin
              if (i == 0)      x_q[i] <= x_first;
              else if (i == 1) x_q[i] <= x_second;
              else             x_q[i] <= '0;
            end
            tgt_q     <= (target > ONE_Q12) ? ONE_Q12 : target;
            wval_q    <= weight_value;
            idx_ok    <= idx32 < 32'(TOTAL);
            widx      <= (mode == MODE_TRAIN || mode == MODE_INFER) ? '0 : idx32[WI_W-1:0];
            c         <= '0;
            h         <= '0;
            layer_out <= 1'b0;
            acc       <= '0;
            clip      <= 1'b0;
            y_q       <= '0;
            res_w     <= '0;
            case (mode)
              MODE_LOAD: state <= S_LOAD;
              MODE_READ: state <= S_READ;
              default:   state <= S_F_RD;
            endcase
          end
        end
        S_LOAD:  state <= S_DONE;
        S_READ:  state <= S_READ2;
        S_READ2: begin
          res_w <= idx_ok ? wrd : '0;
          state <= S_DONE;
        end
        S_F_RD:  state <= S_F_MUL;
        S_F_MUL: state <= S_F_ACC;
        S_F_ACC: begin
          acc  <= acc + mul_p[ACC_W-1:0];
          widx <= widx + 1'b1;
          if (last_term) begin
            c     <= '0;
            state <= S_SG_U;
          end else begin
            c     <= c + 1'b1;
            state <= S_F_RD;
          end
        end
        S_SG_U:  state <= S_SG_LO;
        S_SG_LO: begin
          sidx  <= idx_c;
          sfrac <= mul_p[15:0];
          state <= S_SG_HI;
        end
        S_SG_HI: begin
          lo_q  <= rom_q;
          state <= S_SG_MUL;
        end
        S_SG_MUL: state <= S_SG_FIN;
        S_SG_FIN: begin
          acc <= '0;
          if (!layer_out) begin
            for (int i = 0; i < HIDDEN_UNITS; i++) begin
              if (h == CNT_W'(i)) z_q[i] <= sg_sum[Y_W-1:0];
            end
            if (last_h) begin
              layer_out <= 1'b1;
              h         <= '0;
            end else begin
              h <= h + 1'b1;
            end
            state <= S_F_RD;
          end else begin
            y_q   <= sg_sum[Y_W-1:0];
            state <= (mode_q == MODE_INFER) ? S_DONE : S_D1;
          end
        end
        S_D1: state <= S_D2;
        S_D2: state <= S_D3;
        S_D3: begin
          delta_q <= mul_p[37:24];
          widx    <= WI_W'(HID_COUNT + 1);
          h       <= '0;
          state   <= S_H_RD;
        end
        S_H_RD:   state <= S_H_MUL1;
        S_H_MUL1: state <= S_H_MUL2;
        S_H_MUL2: state <= S_H_MUL3;
        S_H_MUL3: state <= S_H_FIN;
        S_H_FIN: begin
          for (int i = 0; i < HIDDEN_UNITS; i++) begin
            if (h == CNT_W'(i)) dh_q[i] <= mul_p[42:24];
          end
          if (last_h) begin
            widx      <= '0;
            h         <= '0;
            c         <= '0;
            layer_out <= 1'b0;
            state     <= S_U_A;
          end else begin
            h     <= h + 1'b1;
            widx  <= widx + 1'b1;
            state <= S_H_RD;
          end
        end
        S_U_A: state <= S_U_B;
        S_U_B: state <= S_U_WR;
        S_U_WR: begin
          clip  <= clip | wclip;
          widx  <= widx + 1'b1;
          if (layer_out && last_term) state <= S_DONE;
          else                        state <= S_U_A;
          if (layer_out) begin
            if (!last_term) c <= c + 1'b1;
          end else if (last_term) begin
            c <= '0;
            if (last_h) begin
              layer_out <= 1'b1;
              h         <= '0;
            end else begin
              h <= h + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            net_output  <= y_q;
            weight_read <= res_w;
            saturated   <= clip;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold off new transactions while one is in progress
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    w_en |-> (32'(widx) < 32'(TOTAL)))
    else $error("weight write beyond the weight store");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> net_output <= ONE_Q12)
    else $error("network output above one");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && weight_read != '0 |-> net_output == '0 && !saturated)
    else $error("read result mixed with forward result");

  a_sat_train: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && clip |-> mode_q == MODE_TRAIN)
    else $error("saturation flagged outside training");

endmodule
